// ----- design/owik_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the omni-wheel
// inverse kinematics block. No dependencies; every other design file uses it.
package owik_pkg;

   localparam int WHEEL_COUNT     = 4;
   localparam int WHEEL_W         = 2;
   localparam int TRIG_TABLE_BITS = 10;
   localparam int TRIG_N          = 1 << TRIG_TABLE_BITS;
   localparam int TRIG_QUARTER    = TRIG_N / 4;
   localparam int QTR_BITS        = TRIG_TABLE_BITS - 2;
   localparam int QADDR_W         = QTR_BITS + 1;
   localparam int HEAD_SHIFT      = 16 - TRIG_TABLE_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int COEF_W      = 48;
   localparam int ROT_W       = 32;
   localparam int TURN_PROD_W = 32;
   localparam int PROD_W      = 48;
   localparam int ACC_W       = 48;
   localparam int FRAC_SHIFT  = 28;
   localparam int DIST_SHIFT  = 12;
   localparam int QUOT_W      = ACC_W - FRAC_SHIFT;

   localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
      ACC_W'((64'd1 << FRAC_SHIFT) - 64'd1);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] field_vx;
      logic signed [15:0] field_vy;
      logic signed [15:0] turn_rate;
      logic        [15:0] heading;
   } owik_req_type;

   typedef struct packed {
      logic [WHEEL_W-1:0] wheel_index;
      logic signed [15:0] wheel_speed;
      logic               last_wheel;
   } owik_rsp_type;

   // Layout matches the coefficient register: cosine on top, distance at the bottom
   typedef struct packed {
      logic signed [15:0] cosine;
      logic signed [15:0] sine;
      logic signed [15:0] distance;
   } owik_coef_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] rot_x;
      logic signed [ROT_W-1:0] rot_y;
      logic signed [15:0]      turn_rate;
   } owik_cmd_type;

   typedef struct packed {
      logic         valid;
      owik_cmd_type cmd;
   } owik_push_type;

   typedef logic [TRIG_QUARTER:0][14:0] owik_qtable_type;

   // Q30 Taylor series of the first quadrant, rounded half up to Q14.
   // Terms past the twelfth are zero at this precision.
   function automatic owik_qtable_type build_qtable();
      owik_qtable_type   tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       t;
      logic signed [63:0] sum;
      logic [63:0]       rounded;
      tab = '0;
      for (int k = 0; k <= TRIG_QUARTER; k++) begin
         x   = (HALF_PI_Q30 * 64'(k)) / 64'(TRIG_QUARTER);
         x2  = (x * x) >> 30;
         t   = x;
         sum = $signed(t);
         t = ((t * x2) >> 30) / 64'd6;   sum = sum - $signed(t);
         t = ((t * x2) >> 30) / 64'd20;  sum = sum + $signed(t);
         t = ((t * x2) >> 30) / 64'd42;  sum = sum - $signed(t);
         t = ((t * x2) >> 30) / 64'd72;  sum = sum + $signed(t);
         t = ((t * x2) >> 30) / 64'd110; sum = sum - $signed(t);
         t = ((t * x2) >> 30) / 64'd156; sum = sum + $signed(t);
         t = ((t * x2) >> 30) / 64'd210; sum = sum - $signed(t);
         t = ((t * x2) >> 30) / 64'd272; sum = sum + $signed(t);
         t = ((t * x2) >> 30) / 64'd342; sum = sum - $signed(t);
         t = ((t * x2) >> 30) / 64'd420; sum = sum + $signed(t);
         t = ((t * x2) >> 30) / 64'd506; sum = sum - $signed(t);
         if (sum < 0) begin
            sum = '0;
         end
         rounded = ($unsigned(sum) + 64'h8000) >> 16;
         tab[k]  = rounded[14:0];
      end
      return tab;
   endfunction

   localparam owik_qtable_type TRIG_QTABLE = build_qtable();

   // Full-turn sine from the quarter table: mirror in odd quadrants, negate in the lower half
   function automatic logic signed [15:0] trig_lookup(input logic [TRIG_TABLE_BITS-1:0] idx);
      logic [QADDR_W-1:0] addr;
      logic [14:0]        mag;
      if (idx[TRIG_TABLE_BITS-2]) begin
         addr = QADDR_W'(TRIG_QUARTER) - {1'b0, idx[QTR_BITS-1:0]};
      end else begin
         addr = {1'b0, idx[QTR_BITS-1:0]};
      end
      mag = TRIG_QTABLE[addr];
      return idx[TRIG_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

// ----- design/owik_front.sv -----
// Front end: registers an accepted command, looks up heading sine and cosine,
// and rotates the field-frame velocity into the robot frame. Uses owik_pkg.
module owik_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  owik_pkg::owik_req_type req_data,
   output owik_pkg::owik_push_type push
);

   logic [16:0]                          head_round;
   logic [owik_pkg::TRIG_TABLE_BITS-1:0] sin_idx;
   logic [owik_pkg::TRIG_TABLE_BITS-1:0] cos_idx;

   logic                s1_valid_ff, s1_valid_in;
   logic signed [15:0]  s1_vx_ff, s1_vx_in;
   logic signed [15:0]  s1_vy_ff, s1_vy_in;
   logic signed [15:0]  s1_om_ff, s1_om_in;
   logic signed [15:0]  s1_sin_ff, s1_sin_in;
   logic signed [15:0]  s1_cos_ff, s1_cos_in;

   logic                s2_valid_ff, s2_valid_in;
   logic signed [owik_pkg::ROT_W-1:0] s2_xc_ff, s2_xc_in;
   logic signed [owik_pkg::ROT_W-1:0] s2_ys_ff, s2_ys_in;
   logic signed [owik_pkg::ROT_W-1:0] s2_yc_ff, s2_yc_in;
   logic signed [owik_pkg::ROT_W-1:0] s2_xs_ff, s2_xs_in;
   logic signed [15:0]  s2_om_ff, s2_om_in;

   // Round heading to the nearest table step; the carry out wraps to entry 0
   always_comb begin
      head_round = {1'b0, req_data.heading} + 17'(1 << (owik_pkg::HEAD_SHIFT - 1));
      sin_idx    = head_round[15:owik_pkg::HEAD_SHIFT];
      cos_idx    = sin_idx + owik_pkg::TRIG_TABLE_BITS'(owik_pkg::TRIG_QUARTER);
   end

   always_comb begin
      s1_valid_in = accept;
      s1_vx_in    = req_data.field_vx;
      s1_vy_in    = req_data.field_vy;
      s1_om_in    = req_data.turn_rate;
      s1_sin_in   = owik_pkg::trig_lookup(sin_idx);
      s1_cos_in   = owik_pkg::trig_lookup(cos_idx);
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_xc_in    = s1_vx_ff * s1_cos_ff;
      s2_ys_in    = s1_vy_ff * s1_sin_ff;
      s2_yc_in    = s1_vy_ff * s1_cos_ff;
      s2_xs_in    = s1_vx_ff * s1_sin_ff;
      s2_om_in    = s1_om_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_vx_ff  <= s1_vx_in;
      s1_vy_ff  <= s1_vy_in;
      s1_om_ff  <= s1_om_in;
      s1_sin_ff <= s1_sin_in;
      s1_cos_ff <= s1_cos_in;
      s2_xc_ff  <= s2_xc_in;
      s2_ys_ff  <= s2_ys_in;
      s2_yc_ff  <= s2_yc_in;
      s2_xs_ff  <= s2_xs_in;
      s2_om_ff  <= s2_om_in;
   end

   always_comb begin
      push.valid         = s2_valid_ff;
      push.cmd.rot_x     = s2_xc_ff + s2_ys_ff;
      push.cmd.rot_y     = s2_yc_ff - s2_xs_ff;
      push.cmd.turn_rate = s2_om_ff;
   end

endmodule

// ----- design/owik_queue.sv -----
// Short command queue between front end and wheel engine.
// Overflow is prevented upstream by the in-flight credit count. Uses owik_pkg.
module owik_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  owik_pkg::owik_push_type push,
   input  logic                    pop,
   output owik_pkg::owik_cmd_type  head,
   output logic                    head_valid
);

   owik_pkg::owik_cmd_type              entry_ff [owik_pkg::QUEUE_DEPTH];
   logic [owik_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [owik_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [owik_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   localparam logic [owik_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      owik_pkg::QUEUE_PTR_W'(owik_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

endmodule

// ----- design/owik_back.sv -----
// Wheel engine (uses owik_pkg): holds the wheel coefficient registers and runs one
// wheel per cycle from a valid queue head through multiply, sum and truncate/saturate.
module owik_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [owik_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owik_pkg::COEF_W-1:0]        csr_wdata,
   input  owik_pkg::owik_cmd_type             head,
   input  logic                               head_valid,
   output logic                               pop,
   output logic                               rsp_strobe,
   output owik_pkg::owik_rsp_type             rsp_data
);

   localparam logic [owik_pkg::WHEEL_W-1:0] WHEEL_LAST =
      owik_pkg::WHEEL_W'(owik_pkg::WHEEL_COUNT - 1);

   owik_pkg::owik_coef_type             coef_ff [owik_pkg::WHEEL_COUNT];
   owik_pkg::owik_coef_type             sel;
   logic [owik_pkg::WHEEL_W-1:0]        wheel_ff, wheel_in;

   logic                                b1_valid_ff, b1_valid_in;
   logic [owik_pkg::WHEEL_W-1:0]        b1_wheel_ff, b1_wheel_in;
   logic                                b1_last_ff, b1_last_in;
   logic signed [owik_pkg::PROD_W-1:0]  b1_pc_ff, b1_pc_in;
   logic signed [owik_pkg::PROD_W-1:0]  b1_ps_ff, b1_ps_in;
   logic signed [owik_pkg::TURN_PROD_W-1:0] b1_pd_ff, b1_pd_in;

   logic                                b2_valid_ff, b2_valid_in;
   logic [owik_pkg::WHEEL_W-1:0]        b2_wheel_ff, b2_wheel_in;
   logic                                b2_last_ff, b2_last_in;
   logic signed [owik_pkg::ACC_W-1:0]   b2_acc_ff, b2_acc_in;

   logic signed [owik_pkg::ACC_W-1:0]   acc_adj;
   logic signed [owik_pkg::QUOT_W-1:0]  quot;
   logic signed [15:0]                  speed;

   logic                                rsp_valid_ff, rsp_valid_in;
   owik_pkg::owik_rsp_type              rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < owik_pkg::WHEEL_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < owik_pkg::CSR_INDEX_W'(owik_pkg::WHEEL_COUNT))) begin
         coef_ff[csr_index[owik_pkg::WHEEL_W-1:0]] <= csr_wdata;
      end
   end

   // Step through the wheels of the head command; drop it after the last one
   always_comb begin
      sel = coef_ff[wheel_ff];
      pop = head_valid && (wheel_ff == WHEEL_LAST);
      if (!head_valid) begin
         wheel_in = wheel_ff;
      end else if (pop) begin
         wheel_in = '0;
      end else begin
         wheel_in = wheel_ff + 1'b1;
      end
   end

   always_comb begin
      b1_valid_in = head_valid;
      b1_wheel_in = wheel_ff;
      b1_last_in  = (wheel_ff == WHEEL_LAST);
      b1_pc_in    = head.rot_x * sel.cosine;
      b1_ps_in    = head.rot_y * sel.sine;
      b1_pd_in    = head.turn_rate * sel.distance;
   end

   // Turn term is Q16; scale to the Q28 of the rotation terms
   always_comb begin
      b2_valid_in = b1_valid_ff;
      b2_wheel_in = b1_wheel_ff;
      b2_last_in  = b1_last_ff;
      b2_acc_in   = b1_pc_ff + b1_ps_ff
                  + (owik_pkg::ACC_W'(b1_pd_ff) <<< owik_pkg::DIST_SHIFT);
   end

   // Truncate toward zero: bias negatives before the arithmetic shift, then clamp
   always_comb begin
      acc_adj = b2_acc_ff + (b2_acc_ff[owik_pkg::ACC_W-1] ? owik_pkg::TRUNC_BIAS : '0);
      quot    = acc_adj[owik_pkg::ACC_W-1:owik_pkg::FRAC_SHIFT];
      if (quot > owik_pkg::QUOT_W'(owik_pkg::SPEED_MAX)) begin
         speed = owik_pkg::SPEED_MAX;
      end else if (quot < owik_pkg::QUOT_W'(owik_pkg::SPEED_MIN)) begin
         speed = owik_pkg::SPEED_MIN;
      end else begin
         speed = quot[15:0];
      end
      rsp_valid_in       = b2_valid_ff;
      rsp_in.wheel_index = b2_wheel_ff;
      rsp_in.wheel_speed = speed;
      rsp_in.last_wheel  = b2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff     <= '0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wheel_ff     <= wheel_in;
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_wheel_ff <= b1_wheel_in;
      b1_last_ff  <= b1_last_in;
      b1_pc_ff    <= b1_pc_in;
      b1_ps_ff    <= b1_ps_in;
      b1_pd_ff    <= b1_pd_in;
      b2_wheel_ff <= b2_wheel_in;
      b2_last_ff  <= b2_last_in;
      b2_acc_ff   <= b2_acc_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/omni_wheel_inverse_kinematics.sv -----
// Field-oriented omni-wheel inverse kinematics, top level. Uses owik_pkg,
// owik_front, owik_queue and owik_back.
// Path: an accepted command passes the front end, the queue and the wheel engine;
// the results of one command strobe in consecutive cycles, first wheel to last.
// Throughput: the wheel engine emits one wheel per cycle while the queue holds a
// command; up to 4 commands in flight before busy rises.
// Reset: synchronous; clears the pipeline, queue and coefficient registers.
module omni_wheel_inverse_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  owik_pkg::owik_req_type            req_data,
   output logic                              rsp_strobe,
   output owik_pkg::owik_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [owik_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [owik_pkg::COEF_W-1:0]       csr_wdata
);

   logic                              accept;
   logic                              pop;
   logic                              head_valid;
   owik_pkg::owik_push_type           push;
   owik_pkg::owik_cmd_type            head;
   logic [owik_pkg::QUEUE_CNT_W-1:0]  inflight_ff, inflight_in;

   // Credit count covers the front pipeline and the queue, so the queue never overflows
   assign busy   = (inflight_ff == owik_pkg::QUEUE_CNT_W'(owik_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      case ({accept, pop})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   owik_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   owik_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   owik_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- design/owik_checker.sv -----
// Port-level checks for omni_wheel_inverse_kinematics, attached with bind.
// Uses owik_pkg for the wheel count.
module owik_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_strobe,
   input owik_pkg::owik_rsp_type rsp_data
);

   // A run of wheels comes out in consecutive cycles with rising index
   a_run_consecutive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_wheel |=>
         rsp_strobe && (rsp_data.wheel_index == $past(rsp_data.wheel_index) + 2'd1))
      else $error("wheel run broken or out of order");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_wheel |->
         rsp_data.wheel_index == owik_pkg::WHEEL_W'(owik_pkg::WHEEL_COUNT - 1))
      else $error("last flag on wrong wheel");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.wheel_index != '0) |-> $past(rsp_strobe))
      else $error("wheel run did not start at wheel zero");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe && !busy)
      else $error("activity right after reset");

endmodule

bind omni_wheel_inverse_kinematics owik_checker u_owik_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
